// ===== rtl/dfst_pkg.sv =====
// Package for the depth-first search timestamp block.
// Holds sizes, command and colour codes, the FSM state type and the per-vertex record.
// Depends on nothing; dfst_nbr_find, the top level and the checker refer to it by scoped names.
package dfst_pkg;

  localparam int MaxVertices = 64;
  localparam int VtxW        = $clog2(MaxVertices);
  localparam int CntW        = VtxW + 1;
  localparam int TimeW       = 8;
  localparam int OpW         = 2;

  typedef enum logic [OpW-1:0] {
    OpAddEdge = 2'd0,
    OpRun     = 2'd1,
    OpClear   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ColWhite = 2'd0,
    ColGray  = 2'd1,
    ColBlack = 2'd2
  } colour_e;

  typedef enum logic [3:0] {
    StIdle,
    StEdgeWr,
    StRootRd,
    StRootChk,
    StRowLd,
    StStep,
    StNbrChk,
    StPush,
    StPopRd,
    StPopLd,
    StEmit
  } state_e;

  typedef struct packed {
    colour_e          colour;
    logic [CntW-1:0]  ptr;
    logic [TimeW-1:0] disc;
    logic [TimeW-1:0] fin;
  } info_t;

  typedef struct packed {
    logic            found;
    logic [VtxW-1:0] idx;
  } nbr_t;

  localparam int InfoW = $bits(info_t);

endpackage

// ===== rtl/dfst_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the adjacency rows, vertex records and the stack.
module dfst_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dfst_nbr_find.sv =====
// Finds the lowest set bit of an adjacency row at or above a pointer and below a limit.
// Depends on dfst_pkg.
module dfst_nbr_find (
  input  logic [dfst_pkg::MaxVertices-1:0] row_i,
  input  logic [dfst_pkg::CntW-1:0]        ptr_i,
  input  logic [dfst_pkg::CntW-1:0]        limit_i,
  output dfst_pkg::nbr_t                   nbr_o
);

  always_comb begin
    nbr_o = '0;
    for (int b = dfst_pkg::MaxVertices - 1; b >= 0; b--) begin
      if (row_i[b] && (dfst_pkg::CntW'(b) >= ptr_i) && (dfst_pkg::CntW'(b) < limit_i)) begin
        nbr_o.found = 1'b1;
        nbr_o.idx   = dfst_pkg::VtxW'(b);
      end
    end
  end

endmodule

// ===== rtl/dfs_discovery_finish_times.sv =====
// Top level of the depth-first search timestamp block: command port, control FSM and stores.
// Depends on dfst_pkg, dfst_ram and dfst_nbr_find.
//
//   channel   signals                                          direction  flow control
//   command   start, busy, operation_i, from_vertex_i, to_vertex_i   in   start & !busy
//   result    result_valid_o, vertex_id_o, discovery_time_o,        out  strobe, no back-pressure
//             finish_time_o, last_result_o
//   config    cfg_valid_i, cfg_ready_o, cfg_data_i                   in   valid & ready
//
// An edge load reads the row, then writes it back; a clear is done on acceptance.
// A search over n vertices is paced by the registered read of the vertex record and
// adjacency memories on each step.
// Results then leave one per cycle; busy falls with the cycle of the last result.
// Reset clears the adjacency row valid bits, so the store reads as empty at once.
module dfs_discovery_finish_times (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [dfst_pkg::OpW-1:0]      operation_i,
  input  logic [dfst_pkg::VtxW-1:0]     from_vertex_i,
  input  logic [dfst_pkg::VtxW-1:0]     to_vertex_i,
  output logic                          result_valid_o,
  output logic [dfst_pkg::VtxW-1:0]     vertex_id_o,
  output logic [dfst_pkg::TimeW-1:0]    discovery_time_o,
  output logic [dfst_pkg::TimeW-1:0]    finish_time_o,
  output logic                          last_result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dfst_pkg::CntW-1:0]     cfg_data_i
);

  localparam int Nv = dfst_pkg::MaxVertices;
  localparam int Vw = dfst_pkg::VtxW;
  localparam int Cw = dfst_pkg::CntW;
  localparam int Tw = dfst_pkg::TimeW;

  dfst_pkg::state_e state_q, state_d;

  logic [Cw-1:0] vcount_q, vcount_d;
  logic [Cw-1:0] n_q, n_d;
  logic [Cw-1:0] root_q, root_d;
  logic [Cw-1:0] depth_q, depth_d;
  logic [Tw-1:0] time_q, time_d;
  logic [Vw-1:0] top_u_q, top_u_d;
  logic [Cw-1:0] top_ptr_q, top_ptr_d;
  logic [Tw-1:0] top_disc_q, top_disc_d;
  logic [Nv-1:0] top_row_q, top_row_d;
  logic [Vw-1:0] v_q, v_d;
  logic [Vw-1:0] to_q, to_d;
  logic [Vw-1:0] from_q, from_d;
  logic [Cw-1:0] emit_idx_q, emit_idx_d;
  logic          emit_pend_q, emit_pend_d;
  logic [Vw-1:0] emit_id_q, emit_id_d;
  logic          emit_last_q, emit_last_d;
  logic [Nv-1:0] adj_valid_q, adj_valid_d;
  logic [Nv-1:0] info_valid_q, info_valid_d;
  logic          adj_rvalid_q, adj_rvalid_d;
  logic          info_rvalid_q, info_rvalid_d;

  logic          adj_we, adj_re;
  logic [Vw-1:0] adj_waddr, adj_raddr;
  logic [Nv-1:0] adj_wdata, adj_rdata, adj_row;

  logic                       info_we, info_re;
  logic [Vw-1:0]              info_waddr, info_raddr;
  dfst_pkg::info_t            info_wdata, info_rd;
  logic [dfst_pkg::InfoW-1:0] info_rdata;

  logic          stk_we, stk_re;
  logic [Vw-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  dfst_pkg::nbr_t nbr;
  logic           accept;
  dfst_pkg::op_e  op;
  logic [Tw-1:0]  time_inc;
  logic [Cw-1:0]  depth_pop2;

  dfst_ram #(.Width(Nv), .Depth(Nv)) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .re_i    (adj_re),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  dfst_ram #(.Width(dfst_pkg::InfoW), .Depth(Nv)) u_info_ram (
    .clk_i   (clk_i),
    .we_i    (info_we),
    .waddr_i (info_waddr),
    .wdata_i (info_wdata),
    .re_i    (info_re),
    .raddr_i (info_raddr),
    .rdata_o (info_rdata)
  );

  dfst_ram #(.Width(Vw), .Depth(Nv)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  dfst_nbr_find u_nbr_find (
    .row_i   (top_row_q),
    .ptr_i   (top_ptr_q),
    .limit_i (n_q),
    .nbr_o   (nbr)
  );

  assign busy        = (state_q != dfst_pkg::StIdle);
  assign accept      = start && !busy;
  assign op          = dfst_pkg::op_e'(operation_i);
  assign cfg_ready_o = 1'b1;
  assign time_inc    = time_q + Tw'(1);
  assign depth_pop2  = depth_q - Cw'(2);
  assign adj_row     = adj_rvalid_q ? adj_rdata : '0;

  always_comb begin
    info_rd = dfst_pkg::info_t'(info_rdata);
    if (!info_rvalid_q) begin
      info_rd.colour = dfst_pkg::ColWhite;
      info_rd.ptr    = '0;
    end
  end

  assign result_valid_o   = emit_pend_q;
  assign vertex_id_o      = emit_id_q;
  assign discovery_time_o = info_rd.disc;
  assign finish_time_o    = info_rd.fin;
  assign last_result_o    = emit_last_q;

  always_comb begin
    state_d       = state_q;
    vcount_d      = vcount_q;
    n_d           = n_q;
    root_d        = root_q;
    depth_d       = depth_q;
    time_d        = time_q;
    top_u_d       = top_u_q;
    top_ptr_d     = top_ptr_q;
    top_disc_d    = top_disc_q;
    top_row_d     = top_row_q;
    v_d           = v_q;
    to_d          = to_q;
    from_d        = from_q;
    emit_idx_d    = emit_idx_q;
    emit_pend_d   = 1'b0;
    emit_id_d     = emit_id_q;
    emit_last_d   = emit_last_q;
    adj_valid_d   = adj_valid_q;
    info_valid_d  = info_valid_q;
    adj_rvalid_d  = adj_rvalid_q;
    info_rvalid_d = info_rvalid_q;

    adj_we     = 1'b0;
    adj_waddr  = from_q;
    adj_wdata  = adj_row | (Nv'(1) << to_q);
    adj_re     = 1'b0;
    adj_raddr  = from_vertex_i;
    info_we    = 1'b0;
    info_waddr = top_u_q;
    info_wdata = '{colour: dfst_pkg::ColGray, ptr: top_ptr_q, disc: top_disc_q, fin: '0};
    info_re    = 1'b0;
    info_raddr = v_q;
    stk_we     = 1'b0;
    stk_waddr  = depth_q[Vw-1:0];
    stk_wdata  = v_q;
    stk_re     = 1'b0;
    stk_raddr  = depth_pop2[Vw-1:0];

    if (cfg_valid_i && cfg_ready_o) begin
      vcount_d = cfg_data_i;
    end

    unique case (state_q)
      dfst_pkg::StIdle: begin
        if (accept) begin
          unique case (op)
            dfst_pkg::OpAddEdge: begin
              from_d       = from_vertex_i;
              to_d         = to_vertex_i;
              adj_re       = 1'b1;
              adj_rvalid_d = adj_valid_q[from_vertex_i];
              state_d      = dfst_pkg::StEdgeWr;
            end
            dfst_pkg::OpRun: begin
              n_d          = (vcount_q > Cw'(Nv)) ? Cw'(Nv) : vcount_q;
              info_valid_d = '0;
              time_d       = '0;
              depth_d      = '0;
              root_d       = '0;
              state_d      = dfst_pkg::StRootRd;
            end
            dfst_pkg::OpClear: begin
              adj_valid_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      dfst_pkg::StEdgeWr: begin
        adj_we               = 1'b1;
        adj_valid_d[from_q]  = 1'b1;
        state_d              = dfst_pkg::StIdle;
      end
      dfst_pkg::StRootRd: begin
        if (root_q == n_q) begin
          emit_idx_d = '0;
          state_d    = (n_q == '0) ? dfst_pkg::StIdle : dfst_pkg::StEmit;
        end else begin
          info_re       = 1'b1;
          info_raddr    = root_q[Vw-1:0];
          info_rvalid_d = info_valid_q[root_q[Vw-1:0]];
          state_d       = dfst_pkg::StRootChk;
        end
      end
      dfst_pkg::StRootChk: begin
        if (info_rd.colour == dfst_pkg::ColWhite) begin
          time_d       = time_inc;
          info_we      = 1'b1;
          info_waddr   = root_q[Vw-1:0];
          info_wdata   = '{colour: dfst_pkg::ColGray, ptr: '0, disc: time_inc, fin: '0};
          info_valid_d[root_q[Vw-1:0]] = 1'b1;
          stk_we       = 1'b1;
          stk_waddr    = '0;
          stk_wdata    = root_q[Vw-1:0];
          depth_d      = Cw'(1);
          top_u_d      = root_q[Vw-1:0];
          top_ptr_d    = '0;
          top_disc_d   = time_inc;
          adj_re       = 1'b1;
          adj_raddr    = root_q[Vw-1:0];
          adj_rvalid_d = adj_valid_q[root_q[Vw-1:0]];
          state_d      = dfst_pkg::StRowLd;
        end else begin
          root_d  = root_q + Cw'(1);
          state_d = dfst_pkg::StRootRd;
        end
      end
      dfst_pkg::StRowLd: begin
        top_row_d = adj_row;
        state_d   = dfst_pkg::StStep;
      end
      dfst_pkg::StStep: begin
        if (nbr.found) begin
          top_ptr_d     = Cw'(nbr.idx) + Cw'(1);
          v_d           = nbr.idx;
          info_re       = 1'b1;
          info_raddr    = nbr.idx;
          info_rvalid_d = info_valid_q[nbr.idx];
          state_d       = dfst_pkg::StNbrChk;
        end else begin
          time_d     = time_inc;
          info_we    = 1'b1;
          info_wdata = '{colour: dfst_pkg::ColBlack, ptr: top_ptr_q, disc: top_disc_q,
                         fin: time_inc};
          info_valid_d[top_u_q] = 1'b1;
          depth_d    = depth_q - Cw'(1);
          if (depth_q == Cw'(1)) begin
            root_d  = root_q + Cw'(1);
            state_d = dfst_pkg::StRootRd;
          end else begin
            stk_re  = 1'b1;
            state_d = dfst_pkg::StPopRd;
          end
        end
      end
      dfst_pkg::StNbrChk: begin
        if ((info_rd.colour == dfst_pkg::ColWhite) && (depth_q < Cw'(Nv))) begin
          info_we               = 1'b1;
          info_valid_d[top_u_q] = 1'b1;
          state_d               = dfst_pkg::StPush;
        end else begin
          state_d = dfst_pkg::StStep;
        end
      end
      dfst_pkg::StPush: begin
        time_d       = time_inc;
        info_we      = 1'b1;
        info_waddr   = v_q;
        info_wdata   = '{colour: dfst_pkg::ColGray, ptr: '0, disc: time_inc, fin: '0};
        info_valid_d[v_q] = 1'b1;
        stk_we       = 1'b1;
        depth_d      = depth_q + Cw'(1);
        top_u_d      = v_q;
        top_ptr_d    = '0;
        top_disc_d   = time_inc;
        adj_re       = 1'b1;
        adj_raddr    = v_q;
        adj_rvalid_d = adj_valid_q[v_q];
        state_d      = dfst_pkg::StRowLd;
      end
      dfst_pkg::StPopRd: begin
        top_u_d       = stk_rdata;
        info_re       = 1'b1;
        info_raddr    = stk_rdata;
        info_rvalid_d = info_valid_q[stk_rdata];
        adj_re        = 1'b1;
        adj_raddr     = stk_rdata;
        adj_rvalid_d  = adj_valid_q[stk_rdata];
        state_d       = dfst_pkg::StPopLd;
      end
      dfst_pkg::StPopLd: begin
        top_ptr_d  = info_rd.ptr;
        top_disc_d = info_rd.disc;
        top_row_d  = adj_row;
        state_d    = dfst_pkg::StStep;
      end
      dfst_pkg::StEmit: begin
        info_re       = 1'b1;
        info_raddr    = emit_idx_q[Vw-1:0];
        info_rvalid_d = 1'b1;
        emit_pend_d   = 1'b1;
        emit_id_d     = emit_idx_q[Vw-1:0];
        emit_last_d   = (emit_idx_q + Cw'(1) == n_q);
        emit_idx_d    = emit_idx_q + Cw'(1);
        if (emit_idx_q + Cw'(1) == n_q) begin
          state_d = dfst_pkg::StIdle;
        end
      end
      default: begin
        state_d = dfst_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= dfst_pkg::StIdle;
      vcount_q      <= Cw'(Nv);
      n_q           <= '0;
      root_q        <= '0;
      depth_q       <= '0;
      time_q        <= '0;
      emit_idx_q    <= '0;
      emit_pend_q   <= 1'b0;
      emit_last_q   <= 1'b0;
      adj_valid_q   <= '0;
      info_valid_q  <= '0;
      adj_rvalid_q  <= 1'b0;
      info_rvalid_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      vcount_q      <= vcount_d;
      n_q           <= n_d;
      root_q        <= root_d;
      depth_q       <= depth_d;
      time_q        <= time_d;
      emit_idx_q    <= emit_idx_d;
      emit_pend_q   <= emit_pend_d;
      emit_last_q   <= emit_last_d;
      adj_valid_q   <= adj_valid_d;
      info_valid_q  <= info_valid_d;
      adj_rvalid_q  <= adj_rvalid_d;
      info_rvalid_q <= info_rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_u_q    <= top_u_d;
    top_ptr_q  <= top_ptr_d;
    top_disc_q <= top_disc_d;
    top_row_q  <= top_row_d;
    v_q        <= v_d;
    to_q       <= to_d;
    from_q     <= from_d;
    emit_id_q  <= emit_id_d;
  end

endmodule

// ===== rtl/dfst_checker.sv =====
// Port-level checker for the depth-first search timestamp block, bound to the top level.
// Depends on dfst_pkg and dfs_discovery_finish_times.
module dfst_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic [dfst_pkg::OpW-1:0]   operation_i,
  input logic                       result_valid_o,
  input logic [dfst_pkg::VtxW-1:0]  vertex_id_o,
  input logic [dfst_pkg::TimeW-1:0] discovery_time_o,
  input logic [dfst_pkg::TimeW-1:0] finish_time_o,
  input logic                       last_result_o
);

  // Results of one run leave on consecutive cycles.
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_result_o |=> result_valid_o)
    else $error("result burst broken");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_result_o |=> vertex_id_o == $past(vertex_id_o) + 1'b1)
    else $error("vertex order broken");

  a_times: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (discovery_time_o != '0) && (finish_time_o > discovery_time_o))
    else $error("finish not after discovery");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (operation_i == dfst_pkg::OpRun) |=> busy)
    else $error("run transfer did not raise busy");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_result_o |-> busy)
    else $error("idle during result burst");

endmodule

bind dfs_discovery_finish_times dfst_checker u_dfst_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .operation_i      (operation_i),
  .result_valid_o   (result_valid_o),
  .vertex_id_o      (vertex_id_o),
  .discovery_time_o (discovery_time_o),
  .finish_time_o    (finish_time_o),
  .last_result_o    (last_result_o)
);
